// ===== hdl/lphs_pkg.sv =====
// Package for the linear-probing hash set: widths, codes, the table entry type
// and the state encodings. No dependencies.
package lphs_pkg;

    localparam int KEY_W           = 64;
    localparam int CAP_W           = 11;
    localparam int MUL_W           = 32;
    localparam int DEF_TABLE_DEPTH = 1024;
    localparam int DIV_BITS        = 4;
    localparam int DIV_STEPS       = KEY_W / DIV_BITS;
    localparam int DIV_CNT_W       = $clog2(DIV_STEPS);

    localparam logic [MUL_W-1:0] HASH_MULT   = 32'd2654435761;
    localparam logic [CAP_W-1:0] CAP_RESET   = 11'd1024;

    typedef enum logic {
        OP_INSERT = 1'b0,
        OP_QUERY  = 1'b1
    } op_t;

    typedef struct packed {
        logic             used;
        logic [KEY_W-1:0] key;
    } slot_t;

    typedef enum logic [1:0] {
        H_IDLE,
        H_MUL_LO,
        H_MUL_HI,
        H_DIV
    } hash_state_t;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_HASH,
        ST_CHECK
    } ctrl_state_t;

endpackage

// ===== hdl/lphs_table.sv =====
// Slot memory of the hash set: one write port, one read port with registered data.
// Depends on lphs_pkg for the slot entry type.
module lphs_table #(
    parameter int  TABLE_DEPTH = lphs_pkg::DEF_TABLE_DEPTH,
    localparam int IDX_W       = $clog2(TABLE_DEPTH)
) (
    input  logic                aclk,
    input  logic                wr_en,
    input  logic [IDX_W-1:0]    wr_addr,
    input  lphs_pkg::slot_t     wr_data,
    input  logic [IDX_W-1:0]    rd_addr,
    output lphs_pkg::slot_t     rd_data
);
    import lphs_pkg::*;

    slot_t mem [TABLE_DEPTH];
    slot_t rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== hdl/lphs_hash.sv =====
// Home slot unit: key times the hash multiplier on one shared 32x32 multiplier,
// then the 64-bit product modulo the capacity, four quotient bits per cycle.
// Depends on lphs_pkg.
module lphs_hash #(
    parameter int  TABLE_DEPTH = lphs_pkg::DEF_TABLE_DEPTH,
    localparam int IDX_W       = $clog2(TABLE_DEPTH)
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       start,
    input  logic [lphs_pkg::KEY_W-1:0] key,
    input  logic [lphs_pkg::CAP_W-1:0] cap,
    output logic                       done,
    output logic [IDX_W-1:0]           idx
);
    import lphs_pkg::*;

    hash_state_t          state_reg, state_next;
    logic [KEY_W-1:0]     key_reg, key_next;
    logic [KEY_W-1:0]     prod_reg, prod_next;
    logic [CAP_W-1:0]     rem_reg, rem_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic                 done_reg, done_next;

    logic [MUL_W-1:0]       mul_a;
    logic [2*MUL_W-1:0]     mul_p;
    logic [CAP_W:0]         trial;
    logic [CAP_W-1:0]       rem_step;
    logic [CAP_W+IDX_W-1:0] idx_ext;

    assign mul_a = (state_reg == H_MUL_HI) ? key_reg[KEY_W-1:MUL_W] : key_reg[MUL_W-1:0];
    assign mul_p = mul_a * HASH_MULT;

    // Restoring remainder over the next DIV_BITS product bits, most significant first.
    always_comb begin
        rem_step = rem_reg;
        trial    = '0;
        for (int i = 0; i < DIV_BITS; i++) begin
            trial = {rem_step, prod_reg[KEY_W-1-i]};
            if (trial >= {1'b0, cap}) begin
                trial = trial - {1'b0, cap};
            end
            rem_step = trial[CAP_W-1:0];
        end
    end

    always_comb begin
        state_next = state_reg;
        key_next   = key_reg;
        prod_next  = prod_reg;
        rem_next   = rem_reg;
        cnt_next   = cnt_reg;
        done_next  = 1'b0;
        case (state_reg)
            H_IDLE: begin
                if (start) begin
                    key_next   = key;
                    state_next = H_MUL_LO;
                end
            end
            H_MUL_LO: begin
                prod_next  = mul_p;
                state_next = H_MUL_HI;
            end
            H_MUL_HI: begin
                // Only the low half of the upper partial product survives mod 2^64.
                prod_next  = {prod_reg[KEY_W-1:MUL_W] + mul_p[MUL_W-1:0],
                              prod_reg[MUL_W-1:0]};
                rem_next   = '0;
                cnt_next   = '0;
                state_next = H_DIV;
            end
            H_DIV: begin
                rem_next  = rem_step;
                prod_next = prod_reg << DIV_BITS;
                cnt_next  = cnt_reg + 1'b1;
                if (cnt_reg == DIV_CNT_W'(DIV_STEPS - 1)) begin
                    done_next  = 1'b1;
                    state_next = H_IDLE;
                end
            end
            default: begin
                state_next = H_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= H_IDLE;
            done_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
        key_reg  <= key_next;
        prod_reg <= prod_next;
        rem_reg  <= rem_next;
        cnt_reg  <= cnt_next;
    end

    // The remainder is below the capacity, which never exceeds the table depth.
    assign idx_ext = {{IDX_W{1'b0}}, rem_reg};
    assign idx     = idx_ext[IDX_W-1:0];
    assign done    = done_reg;

endmodule

// ===== hdl/linear_probe_hash_set_unit.sv =====
// Linear-probing hash set of 64-bit keys: one insert or membership request at a time.
// Each request takes two multiply steps, sixteen remainder steps, the home slot read and
// then one probe step per slot examined until a free slot, a match or the capacity is hit.
// A new request is taken only after the last one ends; it cannot end while a result is unread.
// Reset: synchronous, active low; afterwards a clearing pass writes all TABLE_DEPTH slots
// empty before the first request is taken. Capacity resets to 1024.
module linear_probe_hash_set_unit #(
    parameter int TABLE_DEPTH = lphs_pkg::DEF_TABLE_DEPTH
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_we,
    input  logic [lphs_pkg::CAP_W-1:0]        cfg_wdata,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic                              s_op,
    input  logic signed [lphs_pkg::KEY_W-1:0] s_key,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic                              m_present,
    output logic                              m_table_full
);
    import lphs_pkg::*;

    localparam int IDX_W = $clog2(TABLE_DEPTH);

    ctrl_state_t      state_reg, state_next;
    logic [CAP_W-1:0] cap_reg;
    op_t              op_reg, op_next;
    logic [KEY_W-1:0] key_reg, key_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic [CAP_W-1:0] cnt_reg, cnt_next;
    logic [IDX_W-1:0] clr_reg, clr_next;
    logic             m_valid_reg, m_valid_next;
    logic             m_present_reg, m_present_next;
    logic             m_full_reg, m_full_next;

    logic [CAP_W-1:0] eff_cap;
    logic             accept;
    logic             hash_done;
    logic [IDX_W-1:0] hash_idx;
    slot_t            rd_slot;
    slot_t            wr_slot;
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    logic             slot_hit;
    logic             slot_free;
    logic [CAP_W-1:0] visits;
    logic             exhausted;
    logic             out_free;

    always_comb begin
        eff_cap = cap_reg;
        if (cap_reg == '0) begin
            eff_cap = CAP_W'(1);
        end else if (32'(cap_reg) > TABLE_DEPTH) begin
            eff_cap = CAP_W'(TABLE_DEPTH);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cap_reg <= CAP_RESET;
        end else if (cfg_we) begin
            cap_reg <= cfg_wdata;
        end
    end

    assign s_ready = (state_reg == ST_IDLE);
    assign accept  = s_valid && s_ready;

    lphs_hash #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_hash (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (accept),
        .key     (s_key),
        .cap     (eff_cap),
        .done    (hash_done),
        .idx     (hash_idx)
    );

    lphs_table #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_table (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_slot),
        .rd_addr (idx_next),
        .rd_data (rd_slot)
    );

    assign slot_free = !rd_slot.used;
    assign slot_hit  = rd_slot.used && (rd_slot.key == key_reg);
    assign visits    = cnt_reg + 1'b1;
    assign exhausted = (visits == eff_cap);
    assign out_free  = !m_valid_reg || m_ready;

    always_comb begin
        state_next     = state_reg;
        op_next        = op_reg;
        key_next       = key_reg;
        idx_next       = idx_reg;
        cnt_next       = cnt_reg;
        clr_next       = clr_reg;
        m_present_next = m_present_reg;
        m_full_next    = m_full_reg;
        m_valid_next   = m_valid_reg && !m_ready;
        wr_en          = 1'b0;
        wr_addr        = idx_reg;
        wr_slot.used   = 1'b1;
        wr_slot.key    = key_reg;
        case (state_reg)
            ST_CLEAR: begin
                wr_en        = 1'b1;
                wr_addr      = clr_reg;
                wr_slot.used = 1'b0;
                clr_next     = clr_reg + 1'b1;
                if (clr_reg == IDX_W'(TABLE_DEPTH - 1)) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (accept) begin
                    op_next    = op_t'(s_op);
                    key_next   = s_key;
                    state_next = ST_HASH;
                end
            end
            ST_HASH: begin
                // The home slot read is issued in the cycle the hash arrives.
                if (hash_done) begin
                    idx_next   = hash_idx;
                    cnt_next   = '0;
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK: begin
                if (slot_free || slot_hit || exhausted) begin
                    // Hold the read on the same slot until the result register is free.
                    if (out_free) begin
                        wr_en          = slot_free && (op_reg == OP_INSERT);
                        m_valid_next   = 1'b1;
                        m_present_next = slot_hit;
                        m_full_next    = !slot_free && !slot_hit && (op_reg == OP_INSERT);
                        state_next     = ST_IDLE;
                    end
                end else begin
                    cnt_next = visits;
                    if (32'(idx_reg) + 32'd1 >= 32'(eff_cap)) begin
                        idx_next = '0;
                    end else begin
                        idx_next = idx_reg + 1'b1;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            clr_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            clr_reg     <= clr_next;
            m_valid_reg <= m_valid_next;
        end
        op_reg        <= op_next;
        key_reg       <= key_next;
        idx_reg       <= idx_next;
        cnt_reg       <= cnt_next;
        m_present_reg <= m_present_next;
        m_full_reg    <= m_full_next;
    end

    assign m_valid      = m_valid_reg;
    assign m_present    = m_present_reg;
    assign m_table_full = m_full_reg;

endmodule
